// ===== rtl/pfde_pkg.sv =====
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared types, codes and helper functions of the Playfair digraph encipher.
// ----------------------------------------------------------------------------
`default_nettype none

package pfde_pkg;

  // Input operation codes
  localparam logic [1:0] OP_KEY_CHAR  = 2'd0;
  localparam logic [1:0] OP_KEY_END   = 2'd1;
  localparam logic [1:0] OP_TEXT_CHAR = 2'd2;
  localparam logic [1:0] OP_TEXT_END  = 2'd3;

  // Square geometry
  localparam int CELLS   = 25;
  localparam int LETTERS = 26;

  localparam logic [4:0] CELL_COUNT  = 5'd25;
  localparam logic [4:0] LETTER_I    = 5'd8;
  localparam logic [4:0] LETTER_J    = 5'd9;
  localparam logic [4:0] LETTER_Z    = 5'd25;
  localparam logic [2:0] LAST_COLUMN = 3'd4;

  // ASCII bounds
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;
  localparam logic [6:0] ASCII_A      = 7'd97;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cipher_letter;
    logic       pair_last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_KEY,
    CMD_KEY_END,
    CMD_TEXT,
    CMD_TEXT_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [4:0] letter;
    logic       ok;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_CELL,
    S_SQR,
    S_SECOND
  } state_t;

  // Row of a cell index 0..24
  function automatic logic [2:0] cell_row(input logic [4:0] c);
    logic [2:0] r;
    if (c >= 5'd20) r = 3'd4;
    else if (c >= 5'd15) r = 3'd3;
    else if (c >= 5'd10) r = 3'd2;
    else if (c >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  // Column of a cell index 0..24
  function automatic logic [2:0] cell_col(input logic [4:0] c);
    logic [4:0] r5;
    logic [4:0] k;
    r5 = {2'b00, cell_row(c)};
    k  = c - {r5[2:0], 2'b00} - r5;
    return k[2:0];
  endfunction

  // Step one row or column with wrap
  function automatic logic [2:0] wrap_inc(input logic [2:0] x);
    return (x == LAST_COLUMN) ? 3'd0 : x + 3'd1;
  endfunction

  function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] k);
    return {r, 2'b00} + {2'b00, r} + {2'b00, k};
  endfunction

  // Keyless square contents
  function automatic logic [4:0] rst_square_letter(input logic [4:0] c);
    return (c < LETTER_J) ? c : c + 5'd1;
  endfunction

  function automatic logic [4:0] rst_letter_cell(input logic [4:0] l);
    return (l <= LETTER_I) ? l : l - 5'd1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pfde_front.sv =====
// ----------------------------------------------------------------------------
// pfde_front
// Accepts input beats, classifies characters and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pfde_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pfde_pkg::in_item_t in_item,
  output pfde_pkg::head_t        head,
  input  wire logic              pop
);
  import pfde_pkg::*;

  logic [7:0] lc;
  logic       is_let;
  logic [4:0] letter;
  logic       push;
  cmd_t       cmd;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  // Fold case and find the letter index
  always_comb begin
    lc = in_item.char_in;
    if (in_item.char_in >= CHAR_UPPER_A && in_item.char_in <= CHAR_UPPER_Z) begin
      lc = in_item.char_in + CASE_OFFSET;
    end
    is_let = (lc >= CHAR_LOWER_A) && (lc <= CHAR_LOWER_Z);
    letter = 5'(lc - CHAR_LOWER_A);
  end

  // Map the op to a command; non-letters travel with ok low
  always_comb begin
    cmd.kind   = CMD_KEY;
    cmd.letter = letter;
    cmd.ok     = 1'b0;
    unique case (in_item.op)
      OP_KEY_CHAR: begin
        cmd.kind = CMD_KEY;
        cmd.ok   = is_let && (letter != LETTER_J);
      end
      OP_KEY_END: begin
        cmd.kind = CMD_KEY_END;
      end
      OP_TEXT_CHAR: begin
        cmd.kind   = CMD_TEXT;
        cmd.letter = (letter == LETTER_J) ? LETTER_I : letter;
        cmd.ok     = is_let;
      end
      OP_TEXT_END: begin
        cmd.kind = CMD_TEXT_END;
      end
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;

  // Queue pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = q_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== rtl/pfde_back.sv =====
// ----------------------------------------------------------------------------
// pfde_back
// Runs queued commands: key square build, letter pairing and encipher.
// ----------------------------------------------------------------------------
`default_nettype none

module pfde_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pfde_pkg::head_t    head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pfde_pkg::out_item_t     out_item
);
  import pfde_pkg::*;

  state_t     state_r, state_nxt;
  logic [25:0] mask_r, mask_nxt;
  logic [4:0] fill_r, fill_nxt;
  logic       building_r, building_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [4:0] held_r, held_nxt;
  logic [4:0] walk_r, walk_nxt;
  out_item_t  out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [6:0] second_r, second_nxt;

  // Square memories with keyless-square fallback for unwritten entries
  logic [4:0]         sq_mem   [CELLS];
  logic [4:0]         cell_mem [LETTERS];
  logic [CELLS-1:0]   sq_vld_r;
  logic [LETTERS-1:0] cell_vld_r;

  logic       pl_we;
  logic [4:0] pl_letter, pl_cell;
  logic       cre, sre;
  logic [4:0] cra, crb, sra, srb;
  logic [4:0] cell_qa_r, cell_qb_r, sq_qa_r, sq_qb_r;

  logic [25:0] eff_mask;
  logic [4:0]  eff_fill;
  logic        out_free;
  logic [2:0]  ra, ka, rb, kb;
  logic [4:0]  oa, ob;
  logic        walk_place;

  // Shared terms
  always_comb begin
    eff_mask   = building_r ? mask_r : 26'd0;
    eff_fill   = building_r ? fill_r : 5'd0;
    out_free   = !out_valid_r || !out_stall;
    walk_place = (walk_r != LETTER_J) && !mask_r[walk_r] && (fill_r < CELL_COUNT);
    ra = cell_row(cell_qa_r);
    ka = cell_col(cell_qa_r);
    rb = cell_row(cell_qb_r);
    kb = cell_col(cell_qb_r);
    priority if (ra == rb) begin
      oa = cell_at(ra, wrap_inc(ka));
      ob = cell_at(rb, wrap_inc(kb));
    end else if (ka == kb) begin
      oa = cell_at(wrap_inc(ra), ka);
      ob = cell_at(wrap_inc(rb), kb);
    end else begin
      oa = cell_at(ra, kb);
      ob = cell_at(rb, ka);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          unique case (head.cmd.kind)
            CMD_KEY:     state_nxt = S_IDLE;
            CMD_KEY_END: state_nxt = S_FILL;
            CMD_TEXT: begin
              if (building_r) state_nxt = S_FILL;
              else if (held_valid_r && head.cmd.ok) state_nxt = S_CELL;
            end
            CMD_TEXT_END: begin
              if (building_r) state_nxt = S_FILL;
              else if (held_valid_r) state_nxt = S_CELL;
            end
          endcase
        end
      end
      S_FILL:   if (walk_r == LETTER_Z) state_nxt = S_IDLE;
      S_CELL:   state_nxt = S_SQR;
      S_SQR:    if (out_free) state_nxt = S_SECOND;
      S_SECOND: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    pop            = 1'b0;
    pl_we          = 1'b0;
    pl_letter      = head.cmd.letter;
    pl_cell        = eff_fill;
    cre            = 1'b0;
    cra            = held_r;
    crb            = head.cmd.letter;
    sre            = 1'b0;
    sra            = oa;
    srb            = ob;
    mask_nxt       = mask_r;
    fill_nxt       = fill_r;
    building_nxt   = building_r;
    held_valid_nxt = held_valid_r;
    held_nxt       = held_r;
    walk_nxt       = walk_r;
    second_nxt     = second_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          unique case (head.cmd.kind)
            CMD_KEY: begin
              pop          = 1'b1;
              building_nxt = 1'b1;
              mask_nxt     = eff_mask;
              fill_nxt     = eff_fill;
              if (head.cmd.ok && !eff_mask[head.cmd.letter]) begin
                mask_nxt = eff_mask | (26'd1 << head.cmd.letter);
                if (eff_fill < CELL_COUNT) begin
                  pl_we    = 1'b1;
                  fill_nxt = eff_fill + 5'd1;
                end
              end
            end
            CMD_KEY_END: begin
              pop          = 1'b1;
              building_nxt = 1'b1;
              mask_nxt     = eff_mask;
              fill_nxt     = eff_fill;
              walk_nxt     = 5'd0;
            end
            CMD_TEXT: begin
              walk_nxt = 5'd0;
              if (!building_r) begin
                pop = 1'b1;
                // drop non-letters once the square is complete
                if (head.cmd.ok) begin
                  if (!held_valid_r) begin
                    held_nxt       = head.cmd.letter;
                    held_valid_nxt = 1'b1;
                  end else begin
                    held_valid_nxt = 1'b0;
                    cre            = 1'b1;
                  end
                end
              end
            end
            CMD_TEXT_END: begin
              walk_nxt = 5'd0;
              crb      = LETTER_Z;
              if (!building_r) begin
                pop = 1'b1;
                if (held_valid_r) begin
                  held_valid_nxt = 1'b0;
                  cre            = 1'b1;
                end
              end
            end
          endcase
        end
      end
      S_FILL: begin
        pl_letter = walk_r;
        pl_cell   = fill_r;
        if (walk_place) begin
          pl_we    = 1'b1;
          fill_nxt = fill_r + 5'd1;
          mask_nxt = mask_r | (26'd1 << walk_r);
        end
        if (walk_r == LETTER_Z) building_nxt = 1'b0;
        else walk_nxt = walk_r + 5'd1;
      end
      S_CELL: begin
        sre = 1'b1;
      end
      S_SQR: begin
        if (out_free) begin
          out_nxt.cipher_letter = ASCII_A + {2'b00, sq_qa_r};
          out_nxt.pair_last     = 1'b0;
          out_valid_nxt         = 1'b1;
          second_nxt            = ASCII_A + {2'b00, sq_qb_r};
        end
      end
      S_SECOND: begin
        if (out_free) begin
          out_nxt.cipher_letter = second_r;
          out_nxt.pair_last     = 1'b1;
          out_valid_nxt         = 1'b1;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mask_r       <= 26'd0;
      fill_r       <= 5'd0;
      building_r   <= 1'b0;
      held_valid_r <= 1'b0;
      held_r       <= 5'd0;
      out_valid_r  <= 1'b0;
      sq_vld_r     <= '0;
      cell_vld_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      mask_r       <= mask_nxt;
      fill_r       <= fill_nxt;
      building_r   <= building_nxt;
      held_valid_r <= held_valid_nxt;
      held_r       <= held_nxt;
      out_valid_r  <= out_valid_nxt;
      if (pl_we) begin
        sq_vld_r[pl_cell]     <= 1'b1;
        cell_vld_r[pl_letter] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    walk_r   <= walk_nxt;
    out_r    <= out_nxt;
    second_r <= second_nxt;
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (pl_we) begin
      sq_mem[pl_cell]     <= pl_letter;
      cell_mem[pl_letter] <= pl_cell;
    end
  end

  // Registered reads; hold data while not enabled
  always_ff @(posedge clk) begin
    if (cre) begin
      cell_qa_r <= cell_vld_r[cra] ? cell_mem[cra] : rst_letter_cell(cra);
      cell_qb_r <= cell_vld_r[crb] ? cell_mem[crb] : rst_letter_cell(crb);
    end
    if (sre) begin
      sq_qa_r <= sq_vld_r[sra] ? sq_mem[sra] : rst_square_letter(sra);
      sq_qb_r <= sq_vld_r[srb] ? sq_mem[srb] : rst_square_letter(srb);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Commands leave the queue only from idle
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == S_IDLE))
    else $error("command popped outside idle");

  // Fill level never passes the square size
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CELL_COUNT)
    else $error("fill count beyond square");

  // Encipher only runs on a finished square
  a_cell_built: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CELL) |-> !building_r)
    else $error("encipher during key build");

  // While the second letter waits, the first one occupies the output
  a_second_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SECOND) |-> (out_valid_r && !out_r.pair_last))
    else $error("second letter without first in output");

endmodule

`default_nettype wire

// ===== rtl/playfair_digraph_encipher.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_encipher
// Playfair encipher over a character stream with key square build.
// ----------------------------------------------------------------------------
// A pair-completing beat passes the command queue and the cell lookup, square
//   lookup and output registers; the second letter is registered once the
//   first is taken. The back engine takes key and first text letters in idle,
//   runs pairs through the cell, square and second states and runs the fill
//   walk over 26 letters on key end or text during key entry. A 2-entry queue
//   decouples input; reset returns the keyless square at once, no clear pass.
`default_nettype none

module playfair_digraph_encipher (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pfde_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pfde_pkg::out_item_t     out_item
);
  import pfde_pkg::*;

  head_t head;
  logic  pop;

  pfde_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  pfde_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== tb/tb_playfair_digraph_encipher.sv =====
// ----------------------------------------------------------------------------
// tb_playfair_digraph_encipher
// Self-checking bench for the Playfair digraph encipher. A built-in predictor
// tracks the key square and the held text letter. It queues the two cipher
// letters of every completed pair as each beat is accepted, and a monitor
// compares every output beat against the oldest queued letter. Directed
// cases come first, then random key/text sessions with random idling on
// both sides, a long output hold, drain pauses and a final steady stretch.
// ----------------------------------------------------------------------------

module tb_playfair_digraph_encipher;
  timeunit 1ns;
  timeprecision 1ps;

  import pfde_pkg::*;

  localparam int         CLK_PERIOD  = 8;
  localparam int         SIDE        = 5;
  localparam int         DRAIN_LIMIT = 20000;
  localparam int         TAIL_CYCLES = 64;
  localparam int         LONG_HOLD   = 300;
  localparam int         PRINT_CAP   = 30;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Predictor state: square, letter positions, key build and held letter
  logic [4:0]  sq_letter [CELLS];
  logic [4:0]  cell_of [LETTERS];
  logic [25:0] placed_mask;
  logic [4:0]  filled;
  bit          key_open;
  bit          pend_valid;
  logic [4:0]  pend_letter;

  out_item_t cipher_expected[$];

  int  mismatches    = 0;
  int  beats_sent    = 0;
  int  live_beats    = 0;
  int  letters_seen  = 0;
  int  squares_built = 0;
  bit  src_idle_on   = 1'b1;
  bit  sink_idle_on  = 1'b1;
  bit  long_hold_req = 1'b0;

  playfair_digraph_encipher dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Print one line per mismatch (capped) and count it
  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // ---------------------------------------------------------------- predictor

  // Letter index 0..25, or -1 for a dropped byte
  function automatic int fold_letter(input logic [7:0] c);
    logic [7:0] lc;
    lc = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) lc = c + CASE_OFFSET;
    if (lc >= CHAR_LOWER_A && lc <= CHAR_LOWER_Z) return int'(lc - CHAR_LOWER_A);
    return -1;
  endfunction

  task automatic square_reset();
    int pos;
    pos = 0;
    for (int k = 0; k < LETTERS; k++) begin
      if (k != LETTER_J) begin
        sq_letter[pos] = 5'(k);
        cell_of[k]     = 5'(pos);
        pos++;
      end
    end
    cell_of[LETTER_J] = cell_of[LETTER_I];
    placed_mask = '0;
    filled      = '0;
    key_open    = 1'b0;
    pend_valid  = 1'b0;
    pend_letter = '0;
  endtask

  task automatic square_place(input logic [4:0] l);
    if (filled < CELL_COUNT) begin
      sq_letter[filled] = l;
      cell_of[l]        = filled;
      filled            = filled + 5'd1;
    end
    placed_mask[l] = 1'b1;
  endtask

  task automatic key_begin();
    placed_mask = '0;
    filled      = '0;
    key_open    = 1'b1;
  endtask

  // Fill the rest of the square in alphabet order, j excepted
  task automatic key_complete();
    if (!key_open) key_begin();
    for (int k = 0; k < LETTERS; k++) begin
      if (k != LETTER_J && !placed_mask[k]) square_place(5'(k));
    end
    cell_of[LETTER_J] = cell_of[LETTER_I];
    key_open = 1'b0;
    squares_built++;
  endtask

  // Encipher one pair and queue both letters
  task automatic queue_digraph(input logic [4:0] a, input logic [4:0] b);
    int        ca, cb, ra, rb, ka, kb, oa, ob;
    out_item_t r;
    ca = cell_of[a];
    cb = cell_of[b];
    ra = ca / SIDE;
    ka = ca % SIDE;
    rb = cb / SIDE;
    kb = cb % SIDE;
    if (ra == rb) begin
      oa = ra * SIDE + (ka + 1) % SIDE;
      ob = rb * SIDE + (kb + 1) % SIDE;
    end else if (ka == kb) begin
      oa = ((ra + 1) % SIDE) * SIDE + ka;
      ob = ((rb + 1) % SIDE) * SIDE + kb;
    end else begin
      oa = ra * SIDE + kb;
      ob = rb * SIDE + ka;
    end
    r.cipher_letter = ASCII_A + 7'(sq_letter[oa]);
    r.pair_last     = 1'b0;
    cipher_expected.push_back(r);
    r.cipher_letter = ASCII_A + 7'(sq_letter[ob]);
    r.pair_last     = 1'b1;
    cipher_expected.push_back(r);
  endtask

  task automatic predict_beat(input in_item_t b);
    int l;
    l = fold_letter(b.char_in);
    case (b.op)
      OP_KEY_CHAR: begin
        if (!key_open) key_begin();
        if (l >= 0 && l != LETTER_J && !placed_mask[l]) square_place(5'(l));
      end
      OP_KEY_END: begin
        key_complete();
      end
      OP_TEXT_CHAR: begin
        if (key_open) key_complete();
        if (l >= 0) begin
          if (l == LETTER_J) l = LETTER_I;
          if (!pend_valid) begin
            pend_letter = 5'(l);
            pend_valid  = 1'b1;
          end else begin
            pend_valid = 1'b0;
            queue_digraph(pend_letter, 5'(l));
          end
        end
      end
      default: begin
        if (key_open) key_complete();
        if (pend_valid) begin
          pend_valid = 1'b0;
          queue_digraph(pend_letter, LETTER_Z);
        end
      end
    endcase
  endtask

  // ------------------------------------------------------------------ driving

  // Offer one beat from a falling edge, hold it until taken, then maybe idle
  task automatic send_beat(input logic [1:0] op, input logic [7:0] ch);
    in_item_t b;
    b.op      = op;
    b.char_in = ch;
    in_valid <= 1'b1;
    in_item  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(b);
    beats_sent++;
    if (op == OP_KEY_END || op == OP_TEXT_END || fold_letter(ch) >= 0) live_beats++;
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every queued letter has come out
  task automatic wait_drained();
    int n;
    in_valid <= 1'b0;
    n = 0;
    @(posedge clk);
    while (cipher_expected.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (cipher_expected.size() != 0) begin
      report_mismatch($sformatf("%0d cipher letters never arrived",
                                cipher_expected.size()));
      cipher_expected.delete();
    end
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = CHAR_LOWER_A + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1) c = c - CASE_OFFSET;
    return c;
  endfunction

  function automatic logic [7:0] rand_junk();
    if ($urandom_range(0, 2) == 0) return SPACE_CHAR;
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver pacing: random stall bursts, or one long counted hold on request
  initial begin : sink_pacing
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        for (n = 0; n < LONG_HOLD; n++) @(negedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  // Compare every output beat with the oldest queued letter
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      letters_seen++;
      if (cipher_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected beat letter=%0d last=%0b",
                                  out_item.cipher_letter, out_item.pair_last));
      end else begin
        want = cipher_expected.pop_front();
        if (out_item.cipher_letter !== want.cipher_letter)
          report_mismatch($sformatf("cipher_letter got %0d want %0d",
                                    out_item.cipher_letter, want.cipher_letter));
        if (out_item.pair_last !== want.pair_last)
          report_mismatch($sformatf("pair_last got %0b want %0b",
                                    out_item.pair_last, want.pair_last));
      end
    end
  end

  // ------------------------------------------------------------------- tests

  // Keyless square: nothing held, row, column, rectangle, equal letters,
  // j read as i, dropped bytes, and z padding at text end
  task automatic test_text_rules();
    send_beat(OP_TEXT_END, 8'h00);
    send_beat(OP_TEXT_CHAR, "A");
    send_beat(OP_TEXT_CHAR, "b");
    send_beat(OP_TEXT_CHAR, "a");
    send_beat(OP_TEXT_CHAR, SPACE_CHAR);
    send_beat(OP_TEXT_CHAR, "f");
    send_beat(OP_TEXT_CHAR, "j");
    send_beat(OP_TEXT_CHAR, "I");
    send_beat(OP_TEXT_CHAR, 8'hFF);
    send_beat(OP_TEXT_CHAR, "a");
    send_beat(OP_TEXT_CHAR, 8'h00);
    send_beat(OP_TEXT_CHAR, "z");
    send_beat(OP_TEXT_CHAR, "Z");
    send_beat(OP_TEXT_END, 8'hFF);
  endtask

  // Key end without a key, held letter across a key change, repeated, j and
  // dropped key bytes, text and text end arriving during key entry
  task automatic test_key_changes();
    send_beat(OP_KEY_END, 8'h00);
    send_beat(OP_TEXT_CHAR, "q");
    send_beat(OP_KEY_CHAR, "J");
    send_beat(OP_KEY_CHAR, "k");
    send_beat(OP_KEY_CHAR, 8'h00);
    send_beat(OP_KEY_CHAR, "K");
    send_beat(OP_KEY_CHAR, 8'hFF);
    send_beat(OP_KEY_END, 8'hFF);
    send_beat(OP_TEXT_CHAR, "r");
    send_beat(OP_KEY_CHAR, "x");
    send_beat(OP_KEY_CHAR, "y");
    send_beat(OP_TEXT_CHAR, "m");
    send_beat(OP_TEXT_CHAR, "n");
    send_beat(OP_KEY_CHAR, "z");
    send_beat(OP_TEXT_END, 8'h00);
    send_beat(OP_KEY_CHAR, "w");
    send_beat(OP_TEXT_CHAR, SPACE_CHAR);
    send_beat(OP_TEXT_CHAR, "w");
    send_beat(OP_TEXT_CHAR, "a");
    wait_drained();
  endtask

  // Random sessions: mostly key then text, some noise and broken sequences
  task automatic test_random_sessions(input int target, input bit paced);
    int goal, pick, n;
    goal = beats_sent + target;
    while (beats_sent < goal) begin
      if (paced) begin
        src_idle_on  = ($urandom_range(0, 5) != 0);
        sink_idle_on = ($urandom_range(0, 5) != 0);
      end
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        // noise: any op, any byte
        repeat ($urandom_range(1, 6))
          send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          n = $urandom_range(1, 14);
          repeat (n) begin
            if ($urandom_range(0, 7) == 0) send_beat(OP_KEY_CHAR, rand_junk());
            else send_beat(OP_KEY_CHAR, rand_letter());
          end
          // leave key end out now and then so text closes the key
          if ($urandom_range(0, 3) != 0) send_beat(OP_KEY_END, rand_junk());
        end
        n = $urandom_range(1, 24);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) send_beat(OP_TEXT_CHAR, rand_junk());
          else send_beat(OP_TEXT_CHAR, rand_letter());
        end
        if ($urandom_range(0, 1) == 1) send_beat(OP_TEXT_END, rand_junk());
      end
      // pause the sender until every result is out
      if (pick == 11) wait_drained();
    end
  endtask

  // Hold the receiver off while the sender keeps offering letters
  task automatic test_output_hold();
    src_idle_on   = 1'b0;
    long_hold_req = 1'b1;
    repeat (48) send_beat(OP_TEXT_CHAR, rand_letter());
    send_beat(OP_TEXT_END, 8'h00);
    wait_drained();
    src_idle_on = 1'b1;
  endtask

  // Close with a stretch where neither side idles
  task automatic test_steady_stream();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random_sessions(200, 1'b0);
  endtask

  // ----------------------------------------------------------------- sequence

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    square_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_text_rules();
    test_key_changes();
    test_random_sessions(800, 1'b1);
    test_output_hold();
    test_random_sessions(200, 1'b1);
    test_steady_stream();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d beats (%0d letters and ends), %0d squares completed,",
             beats_sent, live_beats, squares_built);
    $display("and %0d cipher letters checked with %0d mismatches.",
             letters_seen, mismatches);
    if (mismatches == 0 && cipher_expected.size() == 0) begin
      $display("** playfair_digraph_encipher: PASSED **");
    end else begin
      $display("** playfair_digraph_encipher: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("Timeout with %0d cipher letters outstanding", cipher_expected.size());
    $display("** playfair_digraph_encipher: FAILED **");
    $finish;
  end

endmodule
